@@ rtl/core/sp3_pkg.sv @@
// Package for the sweep peak and -3 dB edge search block.
// Holds payload structs, register indexes, phase codes and fixed constants.
// Used by sp3_alu, sweep_peak_and_3db_search and sp3_checker.
package sp3_pkg;

  // Field widths of the item payloads.
  localparam int FREQ_W      = 20;
  localparam int START_W     = 18;
  localparam int STEP_W      = 16;
  localparam int CCOUNT_W    = 6;
  localparam int COUNT_W     = 10;
  localparam int LEVEL_W     = 12;
  localparam int INDEX_W     = 9;
  localparam int NORM_W      = 8;
  localparam int PHASE_W     = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;
  localparam int QUOT_W      = 8;

  // Fixed constants of the sweep.
  localparam logic [FREQ_W-1:0]   FREQ_MAX     = 20'hFFFFF;
  localparam logic [FREQ_W-1:0]   DONE_FREQ    = 20'd1000;
  localparam logic [STEP_W-1:0]   THR_Q15      = 16'd23170;
  localparam int                  THR_SHIFT    = 15;
  localparam logic [NORM_W-1:0]   NORM_FULL    = 8'd200;
  localparam logic [CCOUNT_W-1:0] COARSE_LIMIT = 6'd32;

  // Register reset values.
  localparam logic [START_W-1:0]  RST_COARSE_START = 18'd1000;
  localparam logic [STEP_W-1:0]   RST_COARSE_STEP  = 16'd2500;
  localparam logic [CCOUNT_W-1:0] RST_COARSE_COUNT = 6'd20;
  localparam logic [STEP_W-1:0]   RST_FINE_STEP    = 16'd500;
  localparam logic [COUNT_W-1:0]  RST_FINE_COUNT   = 10'd400;
  localparam logic [START_W-1:0]  RST_DRAW_START   = 18'd1000;
  localparam logic [STEP_W-1:0]   RST_DRAW_STEP    = 16'd550;
  localparam logic [COUNT_W-1:0]  RST_DRAW_COUNT   = 10'd280;

  // Sweep phase codes.
  localparam logic [PHASE_W-1:0] PH_COARSE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_FINE   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DRAW   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONE   = 2'd3;

  // Input action codes.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COARSE_START = 3'd0,
    CFG_COARSE_STEP  = 3'd1,
    CFG_COARSE_COUNT = 3'd2,
    CFG_FINE_STEP    = 3'd3,
    CFG_FINE_COUNT   = 3'd4,
    CFG_DRAW_START   = 3'd5,
    CFG_DRAW_STEP    = 3'd6,
    CFG_DRAW_COUNT   = 3'd7
  } cfg_reg_e;

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Input item.
  typedef struct packed {
    logic               action;
    logic [LEVEL_W-1:0] level;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [INDEX_W-1:0] point_index;
    logic [FREQ_W-1:0]  next_freq_hz;
    logic [NORM_W-1:0]  norm_height;
    logic [LEVEL_W-1:0] peak_level;
    logic [LEVEL_W-1:0] threshold_level;
    logic [FREQ_W-1:0]  edge_freq_hz;
    logic               finished;
  } out_item_t;

endpackage

@@ rtl/core/sp3_alu.sv @@
// Shared bit-serial arithmetic unit: shift-add multiply-accumulate and
// restoring divide, one bit per cycle through a single adder.
// Depends on sp3_pkg.
module sp3_alu #(
  parameter int A_W   = 12,
  parameter int ACC_W = 29
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sp3_pkg::alu_req_t           req_i,
  input  logic [A_W-1:0]              a_i,
  input  logic [sp3_pkg::STEP_W-1:0]  b_i,
  input  logic [ACC_W-1:0]            c_i,
  output logic                        done_o,
  output logic [ACC_W-1:0]            prod_o,
  output logic [sp3_pkg::QUOT_W-1:0]  quot_o
);

  localparam int CNT_W = $clog2(A_W + 1);

  logic                  busy_q;
  logic                  done_q;
  sp3_pkg::alu_op_e      op_q;
  logic [ACC_W-1:0]      acc_q;
  logic [ACC_W-1:0]      opnd_q;
  logic [A_W-1:0]        a_q;
  logic [CNT_W-1:0]      cnt_q;

  logic [ACC_W-1:0]      shifted;
  logic [ACC_W-1:0]      add_a;
  logic [ACC_W-1:0]      add_b;
  logic                  cin;
  logic [ACC_W:0]        sum;
  logic                  carry;

  // One adder serves both operations. A divide step subtracts the divisor
  // from the shifted remainder; a carry out means no borrow.
  assign shifted = {acc_q[ACC_W-2:0], a_q[sp3_pkg::QUOT_W-1]};
  assign add_a   = (op_q == sp3_pkg::ALU_DIV) ? shifted : acc_q;
  assign add_b   = (op_q == sp3_pkg::ALU_DIV) ? ~opnd_q : (a_q[0] ? opnd_q : '0);
  assign cin     = (op_q == sp3_pkg::ALU_DIV);
  assign sum     = {1'b0, add_a} + {1'b0, add_b} + (ACC_W + 1)'(cin);
  assign carry   = sum[ACC_W];

  // Load on a request, then one multiplier bit or one quotient bit a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= sp3_pkg::ALU_MUL;
      acc_q  <= '0;
      opnd_q <= '0;
      a_q    <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        acc_q  <= c_i;
        opnd_q <= ACC_W'(b_i);
        a_q    <= a_i;
        cnt_q  <= (req_i.op == sp3_pkg::ALU_DIV) ? CNT_W'(sp3_pkg::QUOT_W) : CNT_W'(A_W);
      end else if (busy_q) begin
        if (op_q == sp3_pkg::ALU_DIV) begin
          acc_q <= carry ? sum[ACC_W-1:0] : shifted;
          a_q   <= {a_q[A_W-2:0], carry};
        end else begin
          acc_q  <= sum[ACC_W-1:0];
          opnd_q <= {opnd_q[ACC_W-2:0], 1'b0};
          a_q    <= {1'b0, a_q[A_W-1:1]};
        end
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
  assign quot_o = a_q[sp3_pkg::QUOT_W-1:0];

endmodule

@@ rtl/core/sweep_peak_and_3db_search.sv @@
// Top level of the swept-response peak and upper -3 dB edge search.
// Contains the item sequencer and sweep state; uses sp3_pkg and sp3_alu.
//
// Usage: a start item (action 0) begins a sweep and returns the first coarse
// frequency. Each measurement item (action 1) carries the level seen at the
// frequency named last and returns the next frequency to program. The sweep
// runs a coarse phase (peak search), a fine phase from the peak frequency
// (point nearest peak*0.7071 gives the upper edge) and a draw phase that
// returns each level normalized to 0..200 of the peak. The result that ends
// the draw phase has finished set. A start while a sweep runs, and a
// measurement while none runs, are dropped without a result.
// Input and result channels are valid/ready; one item is in work at a time.
// A plain point runs one multiply in sp3_alu (the next frequency, or the
// edge frequency at the end of the fine phase); the end of the coarse phase
// runs two, peak frequency then threshold; a draw point that divides runs a
// divide and then a multiply, or only the divide if it closes the sweep; a
// start, or a closing draw point that does not divide, runs neither.
// Input ready returns in the cycle the result becomes valid. A stalled
// receiver holds the result register; a further item is then accepted and
// computed but its result waits until the register frees.
// Reset loads the register defaults and leaves the block idle with no sweep.
module sweep_peak_and_3db_search #(
  parameter int LEVEL_BITS = 12,
  parameter int MAX_POINTS = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sp3_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sp3_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sp3_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [sp3_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int LW    = LEVEL_BITS;
  localparam int PCW   = $clog2(MAX_POINTS + 1);
  localparam int MA    = (PCW > LW) ? PCW : LW;
  localparam int ACW   = MA + 17;
  localparam int NUM_W = LW + 8;
  localparam int FW    = sp3_pkg::FREQ_W;

  localparam logic [ACW-1:0] FreqMaxWide = ACW'(sp3_pkg::FREQ_MAX);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_LAUNCH = 5'b00100,
    S_RUN    = 5'b01000,
    S_POST   = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    J_NEXT  = 3'd0,
    J_PEAKF = 3'd1,
    J_THR   = 3'd2,
    J_EDGE  = 3'd3,
    J_NORM  = 3'd4
  } job_e;

  // Configuration registers.
  logic [sp3_pkg::START_W-1:0]  coarse_start_q;
  logic [sp3_pkg::STEP_W-1:0]   coarse_step_q;
  logic [sp3_pkg::CCOUNT_W-1:0] coarse_cnt_q;
  logic [sp3_pkg::STEP_W-1:0]   fine_step_q;
  logic [sp3_pkg::COUNT_W-1:0]  fine_cnt_q;
  logic [sp3_pkg::START_W-1:0]  draw_start_q;
  logic [sp3_pkg::STEP_W-1:0]   draw_step_q;
  logic [sp3_pkg::COUNT_W-1:0]  draw_cnt_q;

  // Sequencer and sweep state.
  state_e                      state_q;
  job_e                        job_q;
  logic                        busy_q;
  logic [sp3_pkg::PHASE_W-1:0] phase_q;
  logic [PCW-1:0]              pc_q;
  logic [LW-1:0]               peak_q;
  logic [4:0]                  peak_pt_q;
  logic [FW-1:0]               peak_freq_q;
  logic [LW-1:0]               thr_q;
  logic [LW-1:0]               best_dist_q;
  logic [PCW-1:0]              best_pt_q;
  logic [FW-1:0]               edge_q;

  // Item in work and its result fields.
  logic                        act_q;
  logic [LW-1:0]               lvl_q;
  logic [PCW-1:0]              idx_q;
  logic [FW-1:0]               next_q;
  logic [sp3_pkg::NORM_W-1:0]  norm_q;
  logic                        fin_q;
  logic                        out_valid_q;
  sp3_pkg::out_item_t          out_q;

  // Shared unit connections.
  sp3_pkg::alu_req_t           alu_req;
  logic [MA-1:0]               alu_a;
  logic [sp3_pkg::STEP_W-1:0]  alu_b;
  logic [ACW-1:0]              alu_c;
  logic                        alu_done;
  logic [ACW-1:0]              alu_prod;
  logic [sp3_pkg::QUOT_W-1:0]  alu_quot;

  // Derived values.
  logic [PCW-1:0]              coarse_n;
  logic [PCW-1:0]              fine_n;
  logic [PCW-1:0]              draw_n;
  logic [PCW-1:0]              pc_inc;
  logic [LW-1:0]               thr_dist;
  logic [NUM_W-1:0]            num;
  logic [FW-1:0]               prod_sat;

  // Point counts clamped to their legal ranges.
  assign coarse_n = (coarse_cnt_q == '0) ? PCW'(1) :
                    (coarse_cnt_q > sp3_pkg::COARSE_LIMIT) ? PCW'(sp3_pkg::COARSE_LIMIT) :
                    PCW'(coarse_cnt_q);
  assign fine_n   = (fine_cnt_q == '0) ? PCW'(1) :
                    (32'(fine_cnt_q) > 32'(MAX_POINTS)) ? PCW'(MAX_POINTS) : PCW'(fine_cnt_q);
  assign draw_n   = (draw_cnt_q == '0) ? PCW'(1) :
                    (32'(draw_cnt_q) > 32'(MAX_POINTS)) ? PCW'(MAX_POINTS) : PCW'(draw_cnt_q);

  assign pc_inc   = pc_q + PCW'(1);
  assign thr_dist = (lvl_q > thr_q) ? (lvl_q - thr_q) : (thr_q - lvl_q);

  // Level times 200 as shifts and adds: 200 = 128 + 64 + 8.
  assign num      = (NUM_W'(lvl_q) << 7) + (NUM_W'(lvl_q) << 6) + (NUM_W'(lvl_q) << 3);

  assign prod_sat = (alu_prod > FreqMaxWide) ? sp3_pkg::FREQ_MAX : alu_prod[FW-1:0];

  // Operand selection for the shared unit, by job.
  always_comb begin
    alu_req.start = (state_q == S_LAUNCH);
    alu_req.op    = sp3_pkg::ALU_MUL;
    alu_a         = MA'(pc_q);
    alu_b         = draw_step_q;
    alu_c         = ACW'(draw_start_q);
    case (job_q)
      J_NEXT: begin
        if (phase_q == sp3_pkg::PH_COARSE) begin
          alu_b = coarse_step_q;
          alu_c = ACW'(coarse_start_q);
        end else if (phase_q == sp3_pkg::PH_FINE) begin
          alu_b = fine_step_q;
          alu_c = ACW'(peak_freq_q);
        end
      end
      J_PEAKF: begin
        alu_a = MA'(peak_pt_q);
        alu_b = coarse_step_q;
        alu_c = ACW'(coarse_start_q);
      end
      J_THR: begin
        alu_a = MA'(peak_q);
        alu_b = sp3_pkg::THR_Q15;
        alu_c = '0;
      end
      J_EDGE: begin
        alu_a = MA'(best_pt_q);
        alu_b = fine_step_q;
        alu_c = ACW'(peak_freq_q);
      end
      J_NORM: begin
        // The remainder starts below the divisor because level < peak here.
        alu_req.op = sp3_pkg::ALU_DIV;
        alu_a      = MA'(num[sp3_pkg::QUOT_W-1:0]);
        alu_b      = sp3_pkg::STEP_W'(peak_q);
        alu_c      = ACW'(num >> sp3_pkg::QUOT_W);
      end
      default: begin
        alu_a = MA'(pc_q);
      end
    endcase
  end

  sp3_alu #(
    .A_W   (MA),
    .ACC_W (ACW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .c_i    (alu_c),
    .done_o (alu_done),
    .prod_o (alu_prod),
    .quot_o (alu_quot)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_start_q <= sp3_pkg::RST_COARSE_START;
      coarse_step_q  <= sp3_pkg::RST_COARSE_STEP;
      coarse_cnt_q   <= sp3_pkg::RST_COARSE_COUNT;
      fine_step_q    <= sp3_pkg::RST_FINE_STEP;
      fine_cnt_q     <= sp3_pkg::RST_FINE_COUNT;
      draw_start_q   <= sp3_pkg::RST_DRAW_START;
      draw_step_q    <= sp3_pkg::RST_DRAW_STEP;
      draw_cnt_q     <= sp3_pkg::RST_DRAW_COUNT;
    end else if (cfg_we_i) begin
      unique case (sp3_pkg::cfg_reg_e'(cfg_index_i))
        sp3_pkg::CFG_COARSE_START: coarse_start_q <= cfg_wdata_i;
        sp3_pkg::CFG_COARSE_STEP:  coarse_step_q  <= cfg_wdata_i[sp3_pkg::STEP_W-1:0];
        sp3_pkg::CFG_COARSE_COUNT: coarse_cnt_q   <= cfg_wdata_i[sp3_pkg::CCOUNT_W-1:0];
        sp3_pkg::CFG_FINE_STEP:    fine_step_q    <= cfg_wdata_i[sp3_pkg::STEP_W-1:0];
        sp3_pkg::CFG_FINE_COUNT:   fine_cnt_q     <= cfg_wdata_i[sp3_pkg::COUNT_W-1:0];
        sp3_pkg::CFG_DRAW_START:   draw_start_q   <= cfg_wdata_i;
        sp3_pkg::CFG_DRAW_STEP:    draw_step_q    <= cfg_wdata_i[sp3_pkg::STEP_W-1:0];
        sp3_pkg::CFG_DRAW_COUNT:   draw_cnt_q     <= cfg_wdata_i[sp3_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item sequencer: accept, evaluate, run the shared unit, post the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= J_NEXT;
      busy_q      <= 1'b0;
      phase_q     <= sp3_pkg::PH_COARSE;
      pc_q        <= '0;
      peak_q      <= '0;
      peak_pt_q   <= '0;
      peak_freq_q <= '0;
      thr_q       <= '0;
      best_dist_q <= '0;
      best_pt_q   <= '0;
      edge_q      <= '0;
      act_q       <= sp3_pkg::ACT_START;
      lvl_q       <= '0;
      idx_q       <= '0;
      next_q      <= '0;
      norm_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // The result register empties unless a new result is loaded this cycle.
      if (out_valid_q && out_ready_i && (state_q != S_POST)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q   <= in_data_i.action;
            lvl_q   <= LW'(in_data_i.level);
            state_q <= S_EVAL;
          end
        end

        S_EVAL: begin
          // The point counter is zero whenever no sweep runs.
          idx_q <= pc_q;
          if (act_q == sp3_pkg::ACT_START) begin
            if (busy_q) begin
              state_q <= S_IDLE;
            end else begin
              busy_q      <= 1'b1;
              phase_q     <= sp3_pkg::PH_COARSE;
              pc_q        <= '0;
              peak_q      <= '0;
              peak_pt_q   <= '0;
              peak_freq_q <= '0;
              thr_q       <= '0;
              best_dist_q <= '0;
              best_pt_q   <= '0;
              edge_q      <= '0;
              norm_q      <= '0;
              fin_q       <= 1'b0;
              next_q      <= FW'(coarse_start_q);
              state_q     <= S_POST;
            end
          end else if (!busy_q) begin
            state_q <= S_IDLE;
          end else if (phase_q == sp3_pkg::PH_COARSE) begin
            norm_q <= '0;
            fin_q  <= 1'b0;
            // Track the peak; the first of equal levels wins.
            if (lvl_q > peak_q) begin
              peak_q    <= lvl_q;
              peak_pt_q <= pc_q[4:0];
            end
            if (pc_inc >= coarse_n) begin
              phase_q <= sp3_pkg::PH_FINE;
              pc_q    <= '0;
              job_q   <= J_PEAKF;
            end else begin
              pc_q  <= pc_inc;
              job_q <= J_NEXT;
            end
            state_q <= S_LAUNCH;
          end else if (phase_q == sp3_pkg::PH_FINE) begin
            norm_q <= '0;
            fin_q  <= 1'b0;
            // Keep the point nearest the threshold; the first one wins ties.
            if (pc_q == '0 || thr_dist < best_dist_q) begin
              best_dist_q <= thr_dist;
              best_pt_q   <= pc_q;
            end
            if (pc_inc >= fine_n) begin
              phase_q <= sp3_pkg::PH_DRAW;
              pc_q    <= '0;
              next_q  <= FW'(draw_start_q);
              job_q   <= J_EDGE;
            end else begin
              pc_q  <= pc_inc;
              job_q <= J_NEXT;
            end
            state_q <= S_LAUNCH;
          end else begin
            // Draw phase; the last point closes the sweep.
            if (pc_inc >= draw_n) begin
              phase_q <= sp3_pkg::PH_DONE;
              busy_q  <= 1'b0;
              pc_q    <= '0;
              fin_q   <= 1'b1;
              next_q  <= sp3_pkg::DONE_FREQ;
            end else begin
              pc_q  <= pc_inc;
              fin_q <= 1'b0;
            end
            if (peak_q == '0 || lvl_q >= peak_q) begin
              // Saturated height, or the zero peak case, needs no divide.
              norm_q <= (lvl_q == '0) ? '0 : sp3_pkg::NORM_FULL;
              if (pc_inc >= draw_n) begin
                state_q <= S_POST;
              end else begin
                job_q   <= J_NEXT;
                state_q <= S_LAUNCH;
              end
            end else begin
              job_q   <= J_NORM;
              state_q <= S_LAUNCH;
            end
          end
        end

        S_LAUNCH: begin
          state_q <= S_RUN;
        end

        S_RUN: begin
          if (alu_done) begin
            case (job_q)
              J_NEXT: begin
                next_q  <= prod_sat;
                state_q <= S_POST;
              end
              J_PEAKF: begin
                peak_freq_q <= prod_sat;
                next_q      <= prod_sat;
                job_q       <= J_THR;
                state_q     <= S_LAUNCH;
              end
              J_THR: begin
                thr_q   <= LW'(alu_prod >> sp3_pkg::THR_SHIFT);
                state_q <= S_POST;
              end
              J_EDGE: begin
                edge_q  <= prod_sat;
                state_q <= S_POST;
              end
              J_NORM: begin
                norm_q <= alu_quot;
                if (phase_q == sp3_pkg::PH_DONE) begin
                  state_q <= S_POST;
                end else begin
                  job_q   <= J_NEXT;
                  state_q <= S_LAUNCH;
                end
              end
              default: begin
                state_q <= S_POST;
              end
            endcase
          end
        end

        S_POST: begin
          // Load the result register once it is free or being emptied.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q           <= 1'b1;
            out_q.phase           <= phase_q;
            out_q.point_index     <= sp3_pkg::INDEX_W'(idx_q);
            out_q.next_freq_hz    <= next_q;
            out_q.norm_height     <= norm_q;
            out_q.peak_level      <= sp3_pkg::LEVEL_W'(peak_q);
            out_q.threshold_level <= sp3_pkg::LEVEL_W'(thr_q);
            out_q.edge_freq_hz    <= edge_q;
            out_q.finished        <= fin_q;
            state_q               <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/sp3_checker.sv @@
// Port-level checker for sweep_peak_and_3db_search, bound to the top level.
// Depends on sp3_pkg.
module sp3_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input sp3_pkg::out_item_t              out_data_o
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result item changed while stalled");

  // One item in work at a time: ready drops after an accepted item.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready stayed high after an accepted item");

  // The normalized height never exceeds full scale.
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.norm_height <= sp3_pkg::NORM_FULL))
    else $error("norm_height above full scale");

  // The closing result reports the done phase and the parking frequency.
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.finished) |->
      ((out_data_o.phase == sp3_pkg::PH_DONE) &&
       (out_data_o.next_freq_hz == sp3_pkg::DONE_FREQ)))
    else $error("finished result without done phase or parking frequency");

endmodule

bind sweep_peak_and_3db_search sp3_checker u_sp3_checker (.*);

@@ test/sweep_peak_and_3db_search_tb.sv @@
// Self-checking testbench for sweep_peak_and_3db_search: directed and random sweeps,
// with a behavioral predictor of the coarse, fine and draw phases checked item by item.
// Depends on sp3_pkg and the sweep_peak_and_3db_search RTL only.
module sweep_peak_and_3db_search_tb;
  import sp3_pkg::*;

  localparam int          LEVEL_BITS = 12;
  localparam int          MAX_PTS    = 512;
  localparam int          SETTLE     = 40;
  localparam int unsigned IDLE_NONE  = 0;
  localparam int unsigned IDLE_SEND  = 1;
  localparam int unsigned IDLE_RECV  = 2;
  localparam int unsigned IDLE_BOTH  = 3;

  typedef struct {
    in_item_t    item;
    int unsigned mode;
    bit          drain_first;
  } queued_item_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  in_item_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  out_item_t              out_data_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  // Items waiting to be driven and sweep points awaiting their result.
  queued_item_t item_backlog[$];
  out_item_t    awaited_points[$];
  int unsigned  queued_total = 0;
  int unsigned  measured     = 0;
  int unsigned  fault_count  = 0;
  int unsigned  stall_mode   = IDLE_NONE;

  // Shadow copy of the configuration registers.
  logic [START_W-1:0]  cs_start;
  logic [STEP_W-1:0]   cs_step;
  logic [CCOUNT_W-1:0] cs_count;
  logic [STEP_W-1:0]   fn_step;
  logic [COUNT_W-1:0]  fn_count;
  logic [START_W-1:0]  dr_start;
  logic [STEP_W-1:0]   dr_step;
  logic [COUNT_W-1:0]  dr_count;

  // Shadow sweep state.
  logic               sw_busy;
  logic [PHASE_W-1:0] sw_phase;
  int unsigned        sw_count;
  logic [LEVEL_W-1:0] peak_val;
  logic [4:0]         peak_pt;
  logic [FREQ_W-1:0]  peak_hz;
  logic [LEVEL_W-1:0] thr_val;
  logic [LEVEL_W-1:0] best_dist;
  logic [COUNT_W-1:0] best_pt;
  logic [FREQ_W-1:0]  edge_hz;

  sweep_peak_and_3db_search #(
    .LEVEL_BITS(LEVEL_BITS),
    .MAX_POINTS(MAX_PTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [FREQ_W-1:0] clip_hz(input longint unsigned f);
    return (f > FREQ_MAX) ? FREQ_MAX : f[FREQ_W-1:0];
  endfunction

  function automatic int unsigned count_limit(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Decides whether one side idles this cycle under the given idling mode.
  function automatic bit hold_off(input int unsigned mode, input bit sender);
    int unsigned pct;
    case (mode)
      IDLE_SEND: pct = sender ? 59 : 0;
      IDLE_RECV: pct = sender ? 0 : 59;
      IDLE_BOTH: pct = 31;
      default:   pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic clear_sweep_state();
    sw_busy   = 1'b0;
    sw_phase  = PH_COARSE;
    sw_count  = 0;
    peak_val  = '0;
    peak_pt   = '0;
    peak_hz   = '0;
    thr_val   = '0;
    best_dist = '0;
    best_pt   = '0;
    edge_hz   = '0;
  endtask

  // Applies one accepted item to the shadow sweep and queues the result it causes.
  task automatic advance_sweep(input in_item_t it);
    out_item_t          r;
    int unsigned        n;
    int unsigned        q;
    logic [LEVEL_W-1:0] d;
    logic [COUNT_W-1:0] idx;
    r   = '0;
    idx = '0;
    if (it.action == ACT_START) begin
      if (sw_busy) return;
      clear_sweep_state();
      sw_busy = 1'b1;
      r.next_freq_hz = clip_hz(64'(cs_start));
    end else begin
      if (!sw_busy) return;
      idx = sw_count[COUNT_W-1:0];
      case (sw_phase)
        PH_COARSE: begin
          n = count_limit(cs_count, COARSE_LIMIT);
          if (it.level > peak_val) begin
            peak_val = it.level;
            peak_pt  = idx[4:0];
          end
          sw_count = idx + 1;
          if (sw_count >= n) begin
            peak_hz  = clip_hz(64'(cs_start) + 64'(peak_pt) * 64'(cs_step));
            thr_val  = LEVEL_W'((32'(peak_val) * 32'(THR_Q15)) >> THR_SHIFT);
            sw_phase = PH_FINE;
            sw_count = 0;
            r.next_freq_hz = peak_hz;
          end else begin
            r.next_freq_hz = clip_hz(64'(cs_start) + 64'(sw_count) * 64'(cs_step));
          end
        end
        PH_FINE: begin
          n = count_limit(fn_count, MAX_PTS);
          d = (it.level > thr_val) ? it.level - thr_val : thr_val - it.level;
          // The first point closest to the threshold wins.
          if (idx == 0 || d < best_dist) begin
            best_dist = d;
            best_pt   = idx;
          end
          sw_count = idx + 1;
          if (sw_count >= n) begin
            edge_hz  = clip_hz(64'(peak_hz) + 64'(best_pt) * 64'(fn_step));
            sw_phase = PH_DRAW;
            sw_count = 0;
            r.next_freq_hz = clip_hz(64'(dr_start));
          end else begin
            r.next_freq_hz = clip_hz(64'(peak_hz) + 64'(sw_count) * 64'(fn_step));
          end
        end
        default: begin
          n = count_limit(dr_count, MAX_PTS);
          if (peak_val == 0) begin
            r.norm_height = (it.level != 0) ? NORM_FULL : '0;
          end else begin
            q = (32'(it.level) * 32'(NORM_FULL)) / 32'(peak_val);
            r.norm_height = (q > NORM_FULL) ? NORM_FULL : q[NORM_W-1:0];
          end
          sw_count = idx + 1;
          if (sw_count >= n) begin
            sw_phase   = PH_DONE;
            sw_busy    = 1'b0;
            sw_count   = 0;
            r.finished = 1'b1;
            r.next_freq_hz = DONE_FREQ;
          end else begin
            r.next_freq_hz = clip_hz(64'(dr_start) + 64'(sw_count) * 64'(dr_step));
          end
        end
      endcase
    end
    r.phase           = sw_phase;
    r.point_index     = idx[INDEX_W-1:0];
    r.peak_level      = peak_val;
    r.threshold_level = thr_val;
    r.edge_freq_hz    = edge_hz;
    awaited_points.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (fault_count < 100) begin
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    end
    fault_count++;
  endtask

  // Compares one delivered result with the oldest awaited point.
  task automatic check_point(input out_item_t got);
    out_item_t want;
    if (awaited_points.size() == 0) begin
      flag_mismatch("result with nothing awaited", 1, 0);
      return;
    end
    want = awaited_points.pop_front();
    if (got.phase != want.phase) flag_mismatch("phase", got.phase, want.phase);
    if (got.point_index != want.point_index)
      flag_mismatch("point_index", got.point_index, want.point_index);
    if (got.next_freq_hz != want.next_freq_hz)
      flag_mismatch("next_freq_hz", got.next_freq_hz, want.next_freq_hz);
    if (got.norm_height != want.norm_height)
      flag_mismatch("norm_height", got.norm_height, want.norm_height);
    if (got.peak_level != want.peak_level)
      flag_mismatch("peak_level", got.peak_level, want.peak_level);
    if (got.threshold_level != want.threshold_level)
      flag_mismatch("threshold_level", got.threshold_level, want.threshold_level);
    if (got.edge_freq_hz != want.edge_freq_hz)
      flag_mismatch("edge_freq_hz", got.edge_freq_hz, want.edge_freq_hz);
    if (got.finished != want.finished)
      flag_mismatch("finished", got.finished, want.finished);
  endtask

  // Driver: presents queued items and feeds every accepted one to the predictor.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    queued_item_t head;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) advance_sweep(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (item_backlog.size() != 0 &&
            !(item_backlog[0].drain_first && awaited_points.size() != 0) &&
            !hold_off(item_backlog[0].mode, 1'b1)) begin
          head = item_backlog.pop_front();
          in_valid_i <= 1'b1;
          in_data_i  <= head.item;
          stall_mode <= head.mode;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each delivered result and stalls the result channel at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_point(out_data_o);
      out_ready_i <= !hold_off(stall_mode, 1'b0);
    end
  end

  // Writes one register and mirrors it in the shadow copy.
  task automatic program_reg(input cfg_reg_e r, input int unsigned v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_wdata_i <= CFG_DATA_W'(v);
    case (r)
      CFG_COARSE_START: cs_start = START_W'(v);
      CFG_COARSE_STEP:  cs_step  = STEP_W'(v);
      CFG_COARSE_COUNT: cs_count = CCOUNT_W'(v);
      CFG_FINE_STEP:    fn_step  = STEP_W'(v);
      CFG_FINE_COUNT:   fn_count = COUNT_W'(v);
      CFG_DRAW_START:   dr_start = START_W'(v);
      CFG_DRAW_STEP:    dr_step  = STEP_W'(v);
      default:          dr_count = COUNT_W'(v);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_all(input int unsigned c0, input int unsigned c1,
                             input int unsigned c2, input int unsigned c3,
                             input int unsigned c4, input int unsigned c5,
                             input int unsigned c6, input int unsigned c7);
    program_reg(CFG_COARSE_START, c0);
    program_reg(CFG_COARSE_STEP, c1);
    program_reg(CFG_COARSE_COUNT, c2);
    program_reg(CFG_FINE_STEP, c3);
    program_reg(CFG_FINE_COUNT, c4);
    program_reg(CFG_DRAW_START, c5);
    program_reg(CFG_DRAW_STEP, c6);
    program_reg(CFG_DRAW_COUNT, c7);
  endtask

  // Blocks until nothing is queued, driven or awaited, then lets the block settle.
  task automatic wait_drained();
    while (item_backlog.size() != 0 || in_valid_i || awaited_points.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // The idling mode changes every few dozen items so that every phase sees each one.
  task automatic queue_item(input logic act, input int unsigned lvl, input bit drain);
    queued_item_t q;
    q.item.action = act;
    q.item.level  = LEVEL_W'(lvl);
    q.mode        = (queued_total / 48) % 4;
    q.drain_first = drain;
    queued_total++;
    item_backlog.push_back(q);
  endtask

  // A measurement inside a sweep, sometimes preceded by a stray start.
  task automatic queue_measure(input int unsigned lvl);
    if ($urandom_range(0, 15) == 0) queue_item(ACT_START, $urandom_range(0, 4095), 1'b0);
    queue_item(ACT_MEASURE, lvl, 1'b0);
    measured++;
  endtask

  // One complete sweep with random levels shaped to hit ties, the threshold and saturation.
  task automatic queue_sweep(input int unsigned cn, input int unsigned fn,
                             input int unsigned dn, input bit drain);
    int unsigned top;
    int unsigned thr;
    int unsigned style;
    int unsigned lvl;
    int unsigned cap;
    int          t;
    top   = 0;
    style = $urandom_range(0, 2);
    queue_item(ACT_START, $urandom_range(0, 4095), drain);
    for (int i = 0; i < cn; i++) begin
      case (style)
        0:       lvl = $urandom_range(0, 4095);
        1:       lvl = $urandom_range(0, 31);
        default: lvl = $urandom_range(0, 1) ? top : $urandom_range(0, 4095);
      endcase
      if (lvl > top) top = lvl;
      queue_measure(lvl);
    end
    thr = (top * THR_Q15) >> THR_SHIFT;
    for (int i = 0; i < fn; i++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          t = int'(thr) + int'($urandom_range(0, 6)) - 3;
          lvl = (t < 0) ? 0 : ((t > 4095) ? 4095 : t);
        end
        2:       lvl = $urandom_range(0, 4095);
        default: lvl = $urandom_range(0, 1) ? 4095 : 0;
      endcase
      queue_measure(lvl);
    end
    cap = top + top / 4 + 2;
    if (cap > 4095) cap = 4095;
    for (int i = 0; i < dn; i++) begin
      lvl = $urandom_range(0, 1) ? $urandom_range(0, cap) : $urandom_range(0, 4095);
      queue_measure(lvl);
    end
    // Occasionally a measurement arrives with no sweep running.
    if ($urandom_range(0, 3) == 0) queue_item(ACT_MEASURE, $urandom_range(0, 4095), 1'b0);
  endtask

  // Stimulus: directed sweeps first, then random configurations and sweeps.
  initial begin : stimulus
    int unsigned c0, c1, c2, c3, c4, c5, c6, c7;
    int unsigned sweeps;
    cs_start = RST_COARSE_START;
    cs_step  = RST_COARSE_STEP;
    cs_count = RST_COARSE_COUNT;
    fn_step  = RST_FINE_STEP;
    fn_count = RST_FINE_COUNT;
    dr_start = RST_DRAW_START;
    dr_step  = RST_DRAW_STEP;
    dr_count = RST_DRAW_COUNT;
    clear_sweep_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Three points per phase, extreme start and steps.
    program_all(262143, 65535, 3, 0, 3, 0, 65535, 3);
    queue_item(ACT_MEASURE, 4095, 1'b0);
    queue_item(ACT_START, 0, 1'b1);
    queue_item(ACT_START, 4095, 1'b0);
    // Coarse: equal maxima, the first one is the peak.
    queue_item(ACT_MEASURE, 0, 1'b0);
    queue_item(ACT_MEASURE, 4095, 1'b0);
    queue_item(ACT_MEASURE, 4095, 1'b0);
    // Fine: a tie one below and one above the threshold, then an exact hit.
    queue_item(ACT_MEASURE, 2894, 1'b0);
    queue_item(ACT_MEASURE, 2896, 1'b0);
    queue_item(ACT_MEASURE, 2895, 1'b0);
    queue_item(ACT_MEASURE, 4095, 1'b0);
    queue_item(ACT_MEASURE, 0, 1'b0);
    queue_item(ACT_MEASURE, 1, 1'b0);
    queue_item(ACT_MEASURE, 2048, 1'b0);
    // A sweep whose peak is zero.
    queue_item(ACT_START, 0, 1'b1);
    repeat (3) queue_item(ACT_MEASURE, 0, 1'b0);
    queue_item(ACT_MEASURE, 4095, 1'b0);
    queue_item(ACT_MEASURE, 0, 1'b0);
    queue_item(ACT_MEASURE, 0, 1'b0);
    queue_item(ACT_MEASURE, 0, 1'b0);
    queue_item(ACT_MEASURE, 5, 1'b0);
    queue_item(ACT_MEASURE, 4095, 1'b0);

    // Random part: all-zero registers once, all-ones once, random settings otherwise.
    for (int p = 0; p < 6 || measured < 1200; p++) begin
      wait_drained();
      if (p == 1) begin
        c0 = 0; c1 = 0; c2 = 0; c3 = 0; c4 = 0; c5 = 0; c6 = 0; c7 = 0;
      end else if (p == 3) begin
        c0 = 262143; c1 = 65535; c2 = 63; c3 = 65535;
        c4 = 1023;   c5 = 262143; c6 = 65535; c7 = 1023;
      end else begin
        c0 = ($urandom_range(0, 3) == 0) ? 262143 : $urandom_range(0, 262143);
        c1 = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
        c2 = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 63) : $urandom_range(1, 10);
        c3 = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
        c4 = $urandom_range(0, 16);
        c5 = ($urandom_range(0, 3) == 0) ? 262143 : $urandom_range(0, 262143);
        c6 = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
        c7 = $urandom_range(0, 16);
      end
      program_all(c0, c1, c2, c3, c4, c5, c6, c7);
      sweeps = (p == 3) ? 1 : 3;
      for (int s = 0; s < sweeps; s++) begin
        queue_sweep(count_limit(c2 & 63, COARSE_LIMIT), count_limit(c4 & 1023, MAX_PTS),
                    count_limit(c7 & 1023, MAX_PTS), (s == 0) && (p % 2 == 0));
      end
    end

    // Drain, then give late or spurious results a chance to show up.
    while (item_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    for (int k = 0; k < 20000 && awaited_points.size() != 0; k++) @(posedge clk_i);
    if (awaited_points.size() != 0)
      flag_mismatch("results never delivered", 0, awaited_points.size());
    repeat (SETTLE) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("sweep_peak_and_3db_search_tb: clean");
    end else begin
      $display("sweep_peak_and_3db_search_tb: errors");
    end
    $finish;
  end

  // Global watchdog against a hung handshake.
  initial begin
    #6000000;
    $display("sweep_peak_and_3db_search_tb: errors");
    $finish;
  end

endmodule
